[rtl/msos_pkg.sv]
// shared constants, register map and types for the mass-spring oscillator
package msos_pkg;

    localparam int DEF_STATE_WIDTH = 48;

    // field widths
    localparam int CFG_W    = 48;
    localparam int MASS_W   = 32;
    localparam int SPRING_W = 40;
    localparam int STEP_W   = 32;
    localparam int OUT_W    = 48;

    // fraction bits of the coefficients
    localparam int MASS_FRAC   = 24;
    localparam int STEP_FRAC   = 32;
    localparam int SPRING_FRAC = 8;

    // register port
    localparam int APB_DW  = 64;
    localparam int APB_AW  = 6;
    localparam int REG_LSB = 3;

    localparam logic [MASS_W-1:0]   RST_INV_MASS = MASS_W'(16777216);
    localparam logic [SPRING_W-1:0] RST_SPRING   = SPRING_W'(256);
    localparam logic [STEP_W-1:0]   RST_STEP     = STEP_W'(89478);

    typedef enum logic [2:0] {
        REG_INIT_DISP  = 3'd0,
        REG_INIT_VEL   = 3'd1,
        REG_INIT_FORCE = 3'd2,
        REG_INV_MASS   = 3'd3,
        REG_SPRING     = 3'd4,
        REG_STEP       = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        SH_8,
        SH_24,
        SH_32
    } t_shift;

    typedef struct packed {
        logic [CFG_W-1:0]    init_disp;
        logic [CFG_W-1:0]    init_vel;
        logic [CFG_W-1:0]    init_force;
        logic [MASS_W-1:0]   inv_mass;
        logic [SPRING_W-1:0] spring;
        logic [STEP_W-1:0]   step;
    } t_msos_cfg;

    typedef struct packed {
        logic   start;
        t_shift shift;
    } t_mul_ctrl;

endpackage

[rtl/msos_if.sv]
// stream interfaces for the restart requests and the displacement samples
interface msos_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface msos_out_if;
    import msos_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] displacement_out;

    modport source (output valid, output displacement_out, input ready);
    modport sink (input valid, input displacement_out, output ready);
endinterface

[rtl/msos_cfg.sv]
// register file behind the apb-style configuration port
module msos_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [msos_pkg::APB_AW-1:0] paddr,
    input  logic [msos_pkg::APB_DW-1:0] pwdata,
    output logic [msos_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output msos_pkg::t_msos_cfg        o_cfg
);
    import msos_pkg::*;

    t_msos_cfg r_cfg;
    t_reg_idx  w_idx;
    logic      w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:REG_LSB]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.init_disp  <= '0;
            r_cfg.init_vel   <= '0;
            r_cfg.init_force <= '0;
            r_cfg.inv_mass   <= RST_INV_MASS;
            r_cfg.spring     <= RST_SPRING;
            r_cfg.step       <= RST_STEP;
        end else if (w_wr) begin
            case (w_idx)
                REG_INIT_DISP:  r_cfg.init_disp  <= pwdata[CFG_W-1:0];
                REG_INIT_VEL:   r_cfg.init_vel   <= pwdata[CFG_W-1:0];
                REG_INIT_FORCE: r_cfg.init_force <= pwdata[CFG_W-1:0];
                REG_INV_MASS:   r_cfg.inv_mass   <= pwdata[MASS_W-1:0];
                REG_SPRING:     r_cfg.spring     <= pwdata[SPRING_W-1:0];
                REG_STEP:       r_cfg.step       <= pwdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_INIT_DISP:  prdata = APB_DW'(r_cfg.init_disp);
            REG_INIT_VEL:   prdata = APB_DW'(r_cfg.init_vel);
            REG_INIT_FORCE: prdata = APB_DW'(r_cfg.init_force);
            REG_INV_MASS:   prdata = APB_DW'(r_cfg.inv_mass);
            REG_SPRING:     prdata = APB_DW'(r_cfg.spring);
            REG_STEP:       prdata = APB_DW'(r_cfg.step);
            default:        prdata = '0;
        endcase
    end

endmodule

[rtl/msos_serial_mul.sv]
// radix-2 serial multiplier with floor shift and saturation of the product
module msos_serial_mul #(
    parameter int MC_W  = 48,
    parameter int MP_W  = 48,
    parameter int RES_W = 48
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  msos_pkg::t_mul_ctrl      i_ctrl,
    input  logic signed [MC_W-1:0]   i_mcand,
    input  logic [MP_W-1:0]          i_mplier,
    output logic                     o_done,
    output logic signed [RES_W-1:0]  o_result
);
    import msos_pkg::*;

    localparam int PW = MC_W + 1 + MP_W;
    localparam int CW = $clog2(MP_W);

    typedef enum logic [1:0] {
        M_IDLE,
        M_RUN,
        M_SAT
    } t_mstate;

    t_mstate                 r_state;
    logic [CW-1:0]           r_cnt;
    logic signed [MC_W-1:0]  r_mcand;
    logic [MP_W-1:0]         r_mplier;
    logic signed [MC_W:0]    r_hi;
    logic [MP_W-1:0]         r_lo;
    t_shift                  r_shift;
    logic                    r_done;
    logic signed [RES_W-1:0] r_result;

    logic                    w_last;
    logic signed [MC_W+1:0]  w_mc_ext;
    logic signed [MC_W+1:0]  w_add;
    logic signed [MC_W+1:0]  w_sum;
    logic signed [PW-1:0]    w_prod;
    logic signed [PW-1:0]    w_q;
    logic                    w_fits;
    logic signed [RES_W-1:0] w_sat;

    assign o_done   = r_done;
    assign o_result = r_result;

    // top multiplier bit carries negative weight
    assign w_last   = (r_cnt == CW'(MP_W - 1));
    assign w_mc_ext = (MC_W + 2)'(r_mcand);
    assign w_add    = r_mplier[0] ? (w_last ? -w_mc_ext : w_mc_ext) : '0;
    assign w_sum    = (MC_W + 2)'(r_hi) + w_add;

    assign w_prod = $signed({r_hi, r_lo});

    always_comb begin
        case (r_shift)
            SH_8:    w_q = w_prod >>> SPRING_FRAC;
            SH_24:   w_q = w_prod >>> MASS_FRAC;
            SH_32:   w_q = w_prod >>> STEP_FRAC;
            default: w_q = w_prod;
        endcase
    end

    assign w_fits = (&w_q[PW-1:RES_W-1]) || !(|w_q[PW-1:RES_W-1]);

    always_comb begin
        if (w_fits) begin
            w_sat = w_q[RES_W-1:0];
        end else if (w_q[PW-1]) begin
            w_sat = {1'b1, {(RES_W - 1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(RES_W - 1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                M_IDLE: begin
                    if (i_ctrl.start) begin
                        r_mcand  <= i_mcand;
                        r_mplier <= i_mplier;
                        r_shift  <= i_ctrl.shift;
                        r_hi     <= '0;
                        r_lo     <= '0;
                        r_cnt    <= '0;
                        r_state  <= M_RUN;
                    end
                end
                M_RUN: begin
                    r_hi     <= w_sum[MC_W+1:1];
                    r_lo     <= {w_sum[0], r_lo[MP_W-1:1]};
                    r_mplier <= {1'b0, r_mplier[MP_W-1:1]};
                    r_cnt    <= r_cnt + 1'b1;
                    if (w_last) begin
                        r_state <= M_SAT;
                    end
                end
                M_SAT: begin
                    r_result <= w_sat;
                    r_done   <= 1'b1;
                    r_state  <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

endmodule

[rtl/mass_spring_oscillator_step.sv]
// mass-spring oscillator, semi-implicit euler, one displacement sample per request
//
// Channels: i_in carries one request beat per sample with a restart flag; a set
// flag reloads displacement, velocity and force from the initial registers first.
// o_out carries the new displacement (signed Q24.24, saturated) for each request.
// Registers sit behind the apb-style port at 8-byte spacing, pready tied high.
// Sequencing: four dependent products go one after another through a
// single radix-2 serial multiplier that retires one multiplier bit per cycle,
// with max(STATE_WIDTH, 33) multiplier bits per product; one request is worked
// on at a time and i_in.ready is high only between requests.
// Reset (synchronous, active low) clears the state to zero, loads the register
// defaults and empties the output register.
// Stall: the finished sample waits in the output register; a new request may be
// accepted meanwhile, and its result waits for the previous beat to be taken.
module mass_spring_oscillator_step #(
    parameter int STATE_WIDTH = msos_pkg::DEF_STATE_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [msos_pkg::APB_AW-1:0] paddr,
    input  logic [msos_pkg::APB_DW-1:0] pwdata,
    output logic [msos_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    msos_in_if.sink                     i_in,
    msos_out_if.source                  o_out
);
    import msos_pkg::*;

    localparam int SW   = STATE_WIDTH;
    localparam int MC_W = (SW > SPRING_W + 1) ? SW : SPRING_W + 1;
    localparam int MP_W = (SW > STEP_W + 1) ? SW : STEP_W + 1;
    localparam int LD_W = (SW > CFG_W) ? SW : CFG_W;
    localparam int OW_W = (SW > OUT_W) ? SW : OUT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_ACCEL,
        PH_SPEED,
        PH_POS,
        PH_FORCE
    } t_phase;

    t_state               r_state;
    t_phase               r_phase;
    logic signed [SW-1:0] r_pos;
    logic signed [SW-1:0] r_spd;
    logic signed [SW-1:0] r_frc;
    logic signed [SW-1:0] r_acc;
    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out_data;

    t_msos_cfg              w_cfg;
    t_mul_ctrl              w_ctrl;
    logic signed [MC_W-1:0] w_mcand;
    logic [MP_W-1:0]        w_mplier;
    logic                   w_done;
    logic signed [SW-1:0]   w_res;

    function automatic logic signed [SW-1:0] f_sat_add(
        input logic signed [SW-1:0] a,
        input logic signed [SW-1:0] b
    );
        logic signed [SW:0] s;
        s = (SW + 1)'(a) + (SW + 1)'(b);
        if (s[SW] != s[SW-1]) begin
            return s[SW] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
        end
        return s[SW-1:0];
    endfunction

    function automatic logic signed [SW-1:0] f_load(input logic signed [CFG_W-1:0] v);
        logic signed [LD_W-1:0] e;
        e = LD_W'(v);
        if ((&e[LD_W-1:SW-1]) || !(|e[LD_W-1:SW-1])) begin
            return e[SW-1:0];
        end
        return e[LD_W-1] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
    endfunction

    function automatic logic [OUT_W-1:0] f_out(input logic signed [SW-1:0] v);
        logic signed [OW_W-1:0] e;
        e = OW_W'(v);
        if ((&e[OW_W-1:OUT_W-1]) || !(|e[OW_W-1:OUT_W-1])) begin
            return e[OUT_W-1:0];
        end
        return e[OW_W-1] ? {1'b1, {(OUT_W - 1){1'b0}}} : {1'b0, {(OUT_W - 1){1'b1}}};
    endfunction

    msos_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    msos_serial_mul #(
        .MC_W  (MC_W),
        .MP_W  (MP_W),
        .RES_W (SW)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_mcand  (w_mcand),
        .i_mplier (w_mplier),
        .o_done   (w_done),
        .o_result (w_res)
    );

    assign i_in.ready             = (r_state == S_IDLE);
    assign o_out.valid            = r_out_valid;
    assign o_out.displacement_out = r_out_data;

    // operand selection for the product of the current phase
    always_comb begin
        w_ctrl.start = (r_state == S_START);
        case (r_phase)
            PH_ACCEL: begin
                w_mcand      = MC_W'(r_frc);
                w_mplier     = MP_W'($signed(w_cfg.inv_mass));
                w_ctrl.shift = SH_24;
            end
            PH_SPEED: begin
                w_mcand      = MC_W'(r_acc);
                w_mplier     = MP_W'(w_cfg.step);
                w_ctrl.shift = SH_32;
            end
            PH_POS: begin
                w_mcand      = MC_W'(r_spd);
                w_mplier     = MP_W'(w_cfg.step);
                w_ctrl.shift = SH_32;
            end
            PH_FORCE: begin
                // negated spring coefficient gives the restoring sign
                w_mcand      = -MC_W'($signed(w_cfg.spring));
                w_mplier     = MP_W'(r_pos);
                w_ctrl.shift = SH_8;
            end
            default: begin
                w_mcand      = MC_W'(r_frc);
                w_mplier     = MP_W'($signed(w_cfg.inv_mass));
                w_ctrl.shift = SH_24;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_ACCEL;
            r_pos       <= '0;
            r_spd       <= '0;
            r_frc       <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the output state handles a beat leaving on its own
            if (r_out_valid && o_out.ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        if (i_in.restart) begin
                            r_pos <= f_load(w_cfg.init_disp);
                            r_spd <= f_load(w_cfg.init_vel);
                            r_frc <= f_load(w_cfg.init_force);
                        end
                        r_phase <= PH_ACCEL;
                        r_state <= S_START;
                    end
                end
                S_START: r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_done) begin
                        case (r_phase)
                            PH_ACCEL: begin
                                r_acc   <= w_res;
                                r_phase <= PH_SPEED;
                                r_state <= S_START;
                            end
                            PH_SPEED: begin
                                r_spd   <= f_sat_add(r_spd, w_res);
                                r_phase <= PH_POS;
                                r_state <= S_START;
                            end
                            PH_POS: begin
                                r_pos   <= f_sat_add(r_pos, w_res);
                                r_phase <= PH_FORCE;
                                r_state <= S_START;
                            end
                            PH_FORCE: begin
                                r_frc   <= w_res;
                                r_state <= S_OUT;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_OUT: begin
                    // hold until the previous beat has gone
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= f_out(r_pos);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/msos_checker.sv]
// port-level checks for the oscillator, bound to the top level
module msos_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [msos_pkg::OUT_W-1:0]  i_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("output payload changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready && !$rose(i_out_valid))
        else $error("request not held busy after acceptance");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without a request in progress");

endmodule

bind mass_spring_oscillator_step msos_checker u_msos_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.displacement_out)
);

[tb/testbench.sv]
`timescale 1ns / 100ps
// self-checking testbench for the mass-spring oscillator: stream driver, monitor and predictor
module testbench;
    import msos_pkg::*;

    typedef logic signed [127:0] t_wide;

    localparam int    STEP_LATENCY = 4 * (DEF_STATE_WIDTH + 3) + 2;
    localparam int    STALL_LIMIT  = 4000;
    localparam int    LONG_HOLD    = 600;
    localparam int    HOLD_POINT_A = 400;
    localparam int    HOLD_POINT_B = 1000;
    localparam int    REG_COUNT    = 6;
    localparam int    RAND_PHASES  = 10;
    localparam int    PHASE_ITEMS  = 143;
    localparam t_wide STATE_MAX    = {81'd0, {47{1'b1}}};
    localparam t_wide STATE_MIN    = ~STATE_MAX;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    msos_in_if  in_ch ();
    msos_out_if out_ch ();

    mass_spring_oscillator_step u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // register mirror and oscillator state as the block should hold them
    t_msos_cfg          cfg_mirror;
    logic signed [47:0] pos_m;
    logic signed [47:0] spd_m;
    logic signed [47:0] frc_m;

    bit                 restart_q[$];
    logic signed [47:0] disp_expected[$];

    bit in_fire;
    bit out_fire;
    bit tx_burst;
    bit rx_burst;
    int tx_wait;
    int rx_wait;
    int rx_hold;
    int idle_cycles;
    int mismatches;
    int beats_checked;
    int requests_taken;
    int restarts_taken;
    int cfg_writes;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic signed [47:0] clamp_state(t_wide v);
        if (v > STATE_MAX) return STATE_MAX[47:0];
        if (v < STATE_MIN) return STATE_MIN[47:0];
        return v[47:0];
    endfunction

    // exact product, floor shift, then clamp to the state range
    function automatic logic signed [47:0] scaled_product(t_wide a, t_wide b, int frac,
                                                         bit negate);
        t_wide p;
        p = a * b;
        if (negate) p = -p;
        return clamp_state(p >>> frac);
    endfunction

    function automatic logic signed [47:0] advance_oscillator(bit restart);
        logic signed [47:0] accel;
        t_wide              dt;
        t_wide              sum;
        dt = {96'd0, cfg_mirror.step};
        if (restart) begin
            pos_m = $signed(cfg_mirror.init_disp);
            spd_m = $signed(cfg_mirror.init_vel);
            frc_m = $signed(cfg_mirror.init_force);
        end
        accel = scaled_product(frc_m, $signed(cfg_mirror.inv_mass), MASS_FRAC, 1'b0);
        sum   = spd_m;
        sum   = sum + scaled_product(accel, dt, STEP_FRAC, 1'b0);
        spd_m = clamp_state(sum);
        sum   = pos_m;
        sum   = sum + scaled_product(spd_m, dt, STEP_FRAC, 1'b0);
        pos_m = clamp_state(sum);
        frc_m = scaled_product($signed(cfg_mirror.spring), pos_m, SPRING_FRAC, 1'b1);
        return pos_m;
    endfunction

    function automatic int draw_wait(bit burst);
        return burst ? 0 : $urandom_range(0, 11);
    endfunction

    // extremes, zero, small and random values, junk above the register width
    function automatic logic [63:0] draw_field(int width, bit is_signed);
        logic [63:0] mask;
        logic [63:0] raw;
        logic [63:0] junk;
        mask = (64'd1 << width) - 64'd1;
        junk = {$urandom, $urandom};
        raw  = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: raw = is_signed ? (64'd1 << (width - 1)) - 64'd1 : mask;
            1: raw = is_signed ? (64'd1 << (width - 1)) : 64'd0;
            2: raw = 64'd0;
            3: raw = 64'($urandom_range(0, 255));
            4: raw = -64'($urandom_range(1, 255));
            default: ;
        endcase
        return (raw & mask) | (junk & ~mask);
    endfunction

    task automatic note_mismatch(string what, logic signed [47:0] want,
                                 logic signed [47:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %0s: expected %0d actual %0d", what, want, got);
    endtask

    task automatic write_reg(int idx, logic [63:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx << REG_LSB);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_INIT_DISP:  cfg_mirror.init_disp  = value[CFG_W-1:0];
            REG_INIT_VEL:   cfg_mirror.init_vel   = value[CFG_W-1:0];
            REG_INIT_FORCE: cfg_mirror.init_force = value[CFG_W-1:0];
            REG_INV_MASS:   cfg_mirror.inv_mass   = value[MASS_W-1:0];
            REG_SPRING:     cfg_mirror.spring     = value[SPRING_W-1:0];
            REG_STEP:       cfg_mirror.step       = value[STEP_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic push_restarts(bit [7:0] flags, int count);
        for (int i = count - 1; i >= 0; i--)
            restart_q.push_back(flags[i]);
    endtask

    task automatic drain();
        while (restart_q.size() != 0 || disp_expected.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_config();
        if ($urandom_range(0, 9) < 7) begin
            // settings that make the oscillator swing rather than saturate
            write_reg(REG_INIT_DISP, 64'($signed($urandom_range(0, 1 << 28)) - (1 << 27)));
            write_reg(REG_INIT_VEL, 64'($signed($urandom_range(0, 1 << 26)) - (1 << 25)));
            write_reg(REG_INIT_FORCE, 64'($signed($urandom_range(0, 1 << 24)) - (1 << 23)));
            write_reg(REG_INV_MASS, 64'($urandom_range(1 << 22, 1 << 26)));
            write_reg(REG_SPRING, 64'($urandom_range(1, 1 << 24)));
            write_reg(REG_STEP, 64'($urandom_range(1 << 16, 1 << 30)));
        end else begin
            write_reg(REG_INIT_DISP, draw_field(CFG_W, 1'b1));
            write_reg(REG_INIT_VEL, draw_field(CFG_W, 1'b1));
            write_reg(REG_INIT_FORCE, draw_field(CFG_W, 1'b1));
            write_reg(REG_INV_MASS, draw_field(MASS_W, 1'b1));
            write_reg(REG_SPRING, draw_field(SPRING_W, 1'b1));
            write_reg(REG_STEP, draw_field(STEP_W, 1'b0));
        end
    endtask

    // request sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid   <= 1'b0;
            in_ch.restart <= 1'b0;
        end else if (in_ch.valid && !in_fire) begin
            // beat still on offer
        end else begin
            if (in_fire) tx_wait = draw_wait(tx_burst);
            if (tx_wait > 0) begin
                tx_wait--;
                in_ch.valid <= 1'b0;
            end else if (restart_q.size() != 0) begin
                in_ch.valid   <= 1'b1;
                in_ch.restart <= restart_q[0];
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // sample receiver; short stalls count down only while a beat is waiting, long holds always
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_fire) begin
                rx_wait = draw_wait(rx_burst);
                if (beats_checked == HOLD_POINT_A || beats_checked == HOLD_POINT_B)
                    rx_hold = LONG_HOLD;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                out_ch.ready <= 1'b0;
            end else if (rx_wait > 0) begin
                if (out_ch.valid) rx_wait--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // monitor: predicts on each request beat, checks each sample beat
    always @(posedge i_clk) begin
        in_fire  <= i_rst_n && in_ch.valid && in_ch.ready;
        out_fire <= i_rst_n && out_ch.valid && out_ch.ready;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                beats_checked++;
                if (disp_expected.size() == 0)
                    note_mismatch("unexpected sample", 48'sd0, out_ch.displacement_out);
                else if (disp_expected[0] !== out_ch.displacement_out)
                    note_mismatch("displacement_out", disp_expected[0],
                                  out_ch.displacement_out);
                if (disp_expected.size() != 0) void'(disp_expected.pop_front());
            end
            if (in_ch.valid && in_ch.ready) begin
                requests_taken++;
                if (in_ch.restart) restarts_taken++;
                disp_expected.push_back(advance_oscillator(in_ch.restart));
                void'(restart_q.pop_front());
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (restart_q.size() == 0 && disp_expected.size() == 0))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        bit noisy;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_ch.valid   = 1'b0;
        in_ch.restart = 1'b0;
        out_ch.ready  = 1'b0;
        i_rst_n       = 1'b0;
        cfg_mirror    = '{init_disp: '0, init_vel: '0, init_force: '0,
                          inv_mass: RST_INV_MASS, spring: RST_SPRING, step: RST_STEP};
        pos_m = '0;
        spd_m = '0;
        frc_m = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // stepping before any restart stays at zero
        push_restarts(8'b00, 2);
        drain();
        write_reg(REG_INIT_DISP, 64'h0000_0000_0100_0000);
        push_restarts(8'b100, 3);
        drain();
        // everything driven into the upper rail
        write_reg(REG_INIT_DISP, 64'h0000_7FFF_FFFF_FFFF);
        write_reg(REG_INIT_VEL, 64'h0000_7FFF_FFFF_FFFF);
        write_reg(REG_INIT_FORCE, 64'h0000_7FFF_FFFF_FFFF);
        write_reg(REG_INV_MASS, 64'h0000_0000_7FFF_FFFF);
        write_reg(REG_SPRING, 64'h0000_0080_0000_0000);
        write_reg(REG_STEP, 64'h0000_0000_FFFF_FFFF);
        push_restarts(8'b100, 3);
        drain();
        // and into the lower rail
        write_reg(REG_INIT_DISP, 64'h0000_8000_0000_0000);
        write_reg(REG_INIT_VEL, 64'h0000_8000_0000_0000);
        write_reg(REG_INIT_FORCE, 64'h0000_8000_0000_0000);
        write_reg(REG_INV_MASS, 64'h0000_0000_8000_0000);
        write_reg(REG_SPRING, 64'h0000_007F_FFFF_FFFF);
        push_restarts(8'b100, 3);
        drain();
        // zero coefficients freeze the motion
        write_reg(REG_INIT_DISP, 64'h0000_0000_1234_5678);
        write_reg(REG_INV_MASS, 64'd0);
        write_reg(REG_SPRING, 64'd0);
        write_reg(REG_STEP, 64'd0);
        push_restarts(8'b10, 2);
        drain();
        // unmapped addresses must leave the registers alone
        write_reg(REG_COUNT, {$urandom, $urandom});
        write_reg(REG_COUNT + 1, {$urandom, $urandom});
        push_restarts(8'b10, 2);
        drain();
        // negative mass and spring, used as given
        write_reg(REG_INIT_DISP, 64'h0000_0000_0100_0000);
        write_reg(REG_INIT_VEL, 64'hFFFF_FFFF_FF80_0000);
        write_reg(REG_INIT_FORCE, 64'h0000_0000_0040_0000);
        write_reg(REG_INV_MASS, 64'h0000_0000_FF00_0000);
        write_reg(REG_SPRING, 64'h0000_00FF_FFFF_FF00);
        write_reg(REG_STEP, 64'h0000_0000_1000_0000);
        push_restarts(8'b1000, 4);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            random_config();
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            noisy    = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // mostly long free-running stretches started by a restart
                if (noisy)
                    restart_q.push_back(1'($urandom_range(0, 1)));
                else if (i == 0 && $urandom_range(0, 3) != 0)
                    restart_q.push_back(1'b1);
                else
                    restart_q.push_back($urandom_range(0, 99) < 4);
            end
            drain();
        end

        while (disp_expected.size() != 0) @(posedge i_clk);
        repeat (STEP_LATENCY + 50) @(posedge i_clk);
        if (disp_expected.size() != 0)
            note_mismatch("missing sample", disp_expected[0], 48'sd0);
        $display("ran %0d requests (%0d with restart) through %0d register writes,",
                 requests_taken, restarts_taken, cfg_writes);
        $display("checked %0d displacement samples, %0d mismatches", beats_checked,
                 mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
